// File: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/msce_pkg.sv
`timescale 1ns / 1ps

package msce_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam logic [7:0] HIDDEN_Y = 8'hFE;
    localparam logic signed [9:0] UP_BIAS = 10'sd3;
    localparam logic [2:0] LAST_POSE_ROW = 3'd6;

    typedef enum logic [2:0] {
        CFG_SCROLL_X_TILE   = 3'd0,
        CFG_SCROLL_X_SCREEN = 3'd1,
        CFG_SCROLL_X_FINE   = 3'd2,
        CFG_SCROLL_Y_TILE   = 3'd3,
        CFG_SCROLL_Y_SCREEN = 3'd4,
        CFG_SCROLL_Y_FINE   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic              visible;
        logic [3:0]        sprite_idx;
        logic signed [9:0] px;
        logic signed [9:0] py;
        logic [2:0]        row;
        logic [1:0]        phase;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // bit 6 flip, bits 5..0 tile code; address is {row, phase, quadrant}
    localparam logic [6:0] POSE_ROM [112] = '{
        7'h06, 7'h07, 7'h08, 7'h09, 7'h06, 7'h07, 7'h0a, 7'h0b,
        7'h06, 7'h07, 7'h08, 7'h09, 7'h06, 7'h07, 7'h4b, 7'h4a,
        7'h00, 7'h01, 7'h02, 7'h03, 7'h00, 7'h01, 7'h04, 7'h05,
        7'h00, 7'h01, 7'h02, 7'h03, 7'h00, 7'h01, 7'h45, 7'h44,
        7'h0c, 7'h0d, 7'h0e, 7'h0f, 7'h0c, 7'h0d, 7'h10, 7'h11,
        7'h0c, 7'h0d, 7'h0e, 7'h0f, 7'h0c, 7'h0d, 7'h12, 7'h13,
        7'h4d, 7'h4c, 7'h4f, 7'h4e, 7'h4d, 7'h4c, 7'h51, 7'h50,
        7'h4d, 7'h4c, 7'h4f, 7'h4e, 7'h4d, 7'h4c, 7'h53, 7'h52,
        7'h14, 7'h15, 7'h16, 7'h17, 7'h14, 7'h15, 7'h18, 7'h19,
        7'h14, 7'h15, 7'h18, 7'h19, 7'h14, 7'h15, 7'h18, 7'h19,
        7'h55, 7'h54, 7'h57, 7'h56, 7'h55, 7'h54, 7'h59, 7'h58,
        7'h55, 7'h54, 7'h59, 7'h58, 7'h55, 7'h54, 7'h59, 7'h58,
        7'h1a, 7'h1b, 7'h1c, 7'h1d, 7'h1a, 7'h1b, 7'h1c, 7'h1d,
        7'h1a, 7'h1b, 7'h1c, 7'h1d, 7'h1a, 7'h1b, 7'h1c, 7'h1d
    };

endpackage

// File: hw/rtl/msce_front.sv
`timescale 1ns / 1ps

module msce_front #(
    parameter int SCREEN_TILES_WIDE = 16,
    parameter int SCREEN_TILES_HIGH = 15,
    parameter int SPRITE_COUNT      = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [3:0]           i_sprite_index,
    input  logic [7:0]           i_x_tile,
    input  logic [7:0]           i_x_screen,
    input  logic [3:0]           i_x_fine,
    input  logic [7:0]           i_y_tile,
    input  logic [7:0]           i_y_screen,
    input  logic [3:0]           i_y_fine,
    input  logic [7:0]           i_pose_status,
    input  msce_pkg::t_q_stat    i_q_stat,
    output logic                 o_push,
    output msce_pkg::t_job       o_job
);

    localparam logic [4:0] SPAN_X = 5'(SCREEN_TILES_WIDE);
    localparam logic [4:0] SPAN_Y = 5'(SCREEN_TILES_HIGH);
    localparam logic [4:0] SPRITES = 5'(SPRITE_COUNT);

    logic [7:0] r_sxt, r_sxs, r_syt, r_sys;
    logic [3:0] r_sxf, r_syf;
    logic [7:0] n_sxt, n_sxs, n_syt, n_sys;
    logic [3:0] n_sxf, n_syf;

    logic [5:0] ax, ay;
    logic [2:0] row;

    // returns {in range, tile distance}
    function automatic logic [5:0] axis_tiles(input logic [7:0] tile, input logic [7:0] screen,
                                              input logic [7:0] stile,
                                              input logic [7:0] sscreen,
                                              input logic [4:0] span);
        logic [8:0]        snext;
        logic              same;
        logic              nxt;
        logic signed [10:0] d;
        logic              ok;
        snext = {1'b0, sscreen} + 9'd1;
        same  = (screen == sscreen);
        nxt   = ({1'b0, screen} == snext);
        d     = $signed({3'b000, tile}) - $signed({3'b000, stile})
              + (nxt ? $signed({6'b000000, span}) : 11'sd0);
        ok    = (same || nxt) && !d[10] && (d <= $signed({6'b000000, span}));
        return {ok, d[4:0]};
    endfunction

    always_comb begin
        n_sxt = r_sxt;
        n_sxs = r_sxs;
        n_sxf = r_sxf;
        n_syt = r_syt;
        n_sys = r_sys;
        n_syf = r_syf;
        if (i_cfg_we) begin
            unique case (msce_pkg::t_cfg_idx'(i_cfg_index))
                msce_pkg::CFG_SCROLL_X_TILE:   n_sxt = i_cfg_wdata;
                msce_pkg::CFG_SCROLL_X_SCREEN: n_sxs = i_cfg_wdata;
                msce_pkg::CFG_SCROLL_X_FINE:   n_sxf = i_cfg_wdata[3:0];
                msce_pkg::CFG_SCROLL_Y_TILE:   n_syt = i_cfg_wdata;
                msce_pkg::CFG_SCROLL_Y_SCREEN: n_sys = i_cfg_wdata;
                msce_pkg::CFG_SCROLL_Y_FINE:   n_syf = i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sxt <= '0;
            r_sxs <= '0;
            r_sxf <= '0;
            r_syt <= '0;
            r_sys <= '0;
            r_syf <= '0;
        end else begin
            r_sxt <= n_sxt;
            r_sxs <= n_sxs;
            r_sxf <= n_sxf;
            r_syt <= n_syt;
            r_sys <= n_sys;
            r_syf <= n_syf;
        end
    end

    always_comb begin
        ax  = axis_tiles(i_x_tile, i_x_screen, r_sxt, r_sxs, SPAN_X);
        ay  = axis_tiles(i_y_tile, i_y_screen, r_syt, r_sys, SPAN_Y);
        row = (i_pose_status[7:4] > {1'b0, msce_pkg::LAST_POSE_ROW})
            ? msce_pkg::LAST_POSE_ROW : i_pose_status[6:4];

        o_job.visible    = ax[5] && ay[5];
        o_job.sprite_idx = i_sprite_index;
        o_job.px = $signed({1'b0, ax[4:0], 4'b0000}) + $signed({6'b000000, i_x_fine})
                 - $signed({6'b000000, r_sxf});
        o_job.py = $signed({1'b0, ay[4:0], 4'b0000}) + $signed({6'b000000, i_y_fine})
                 - $signed({6'b000000, r_syf}) - msce_pkg::UP_BIAS;
        o_job.row   = row;
        o_job.phase = i_pose_status[1:0];
    end

    assign o_in_ready = !i_q_stat.full;
    // sprites past the configured count are taken and dropped
    assign o_push = i_in_valid && o_in_ready && ({1'b0, i_sprite_index} < SPRITES);

endmodule

// File: hw/rtl/msce_queue.sv
`timescale 1ns / 1ps

module msce_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  msce_pkg::t_job     i_job,
    input  logic               i_pop,
    output msce_pkg::t_job     o_head,
    output msce_pkg::t_q_stat  o_stat
);

    localparam int DEPTH = msce_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    msce_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic do_push, do_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        priority if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: hw/rtl/msce_back.sv
`timescale 1ns / 1ps

module msce_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  msce_pkg::t_job     i_head,
    input  msce_pkg::t_q_stat  i_q_stat,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [5:0]         o_oam_entry,
    output logic [7:0]         o_x_pos,
    output logic [7:0]         o_y_pos,
    output logic               o_x_written,
    output logic [5:0]         o_tile_code,
    output logic               o_flip,
    output logic               o_tile_written,
    output logic               o_last
);

    logic       r_out_valid, n_out_valid;
    logic [1:0] r_quad, n_quad;
    logic [5:0] r_entry, n_entry;
    logic [7:0] r_x, n_x, r_y, n_y;
    logic       r_xw, n_xw, r_flip, n_flip, r_tw, n_tw, r_last, n_last;
    logic [5:0] r_tile, n_tile;

    logic              out_free, take;
    logic signed [9:0] qx, qy;
    logic [6:0]        rom_v;
    logic              on_screen;

    assign out_free = !r_out_valid || i_out_ready;
    assign take     = !i_q_stat.empty && out_free;
    // job leaves the queue with its fourth quadrant
    assign o_pop    = take && (r_quad == 2'd3);

    always_comb begin
        qx = i_head.px + (r_quad[0] ? 10'sd8 : 10'sd0);
        qy = i_head.py + (r_quad[1] ? 10'sd8 : 10'sd0);
        on_screen = (qx[9:8] == 2'b00) && (qy[9:8] == 2'b00);
        rom_v = msce_pkg::POSE_ROM[{i_head.row, i_head.phase, r_quad}];
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_quad  = r_quad;
        n_entry = r_entry;
        n_x     = r_x;
        n_y     = r_y;
        n_xw    = r_xw;
        n_tile  = r_tile;
        n_flip  = r_flip;
        n_tw    = r_tw;
        n_last  = r_last;
        if (out_free) begin
            n_out_valid = take;
        end
        if (take) begin
            n_quad  = r_quad + 2'd1;
            n_entry = {i_head.sprite_idx, r_quad};
            n_last  = (r_quad == 2'd3);
            n_x     = '0;
            n_y     = msce_pkg::HIDDEN_Y;
            n_xw    = 1'b0;
            n_tile  = '0;
            n_flip  = 1'b0;
            n_tw    = 1'b0;
            if (i_head.visible) begin
                n_tile = rom_v[5:0];
                n_flip = rom_v[6];
                n_tw   = 1'b1;
                if (on_screen) begin
                    n_x  = qx[7:0];
                    n_y  = qy[7:0];
                    n_xw = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_quad      <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_quad      <= n_quad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_x     <= n_x;
        r_y     <= n_y;
        r_xw    <= n_xw;
        r_tile  <= n_tile;
        r_flip  <= n_flip;
        r_tw    <= n_tw;
        r_last  <= n_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_oam_entry    = r_entry;
    assign o_x_pos        = r_x;
    assign o_y_pos        = r_y;
    assign o_x_written    = r_xw;
    assign o_tile_code    = r_tile;
    assign o_flip         = r_flip;
    assign o_tile_written = r_tw;
    assign o_last         = r_last;

endmodule

// File: hw/rtl/metasprite_cull_and_expand_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Turns one 16x16 sprite into four 8x8 attribute entries (top-left, top-right,
// bottom-left, bottom-right, the fourth flagged last). The front stage culls
// and positions the sprite in the cycle it is accepted and drops it into a
// two-deep queue; the back stage emits one entry per cycle from the queue head
// into an output register, unless the receiver stalls. A sprite occupies the
// output port for its four entries; the first entry passes through the queue
// and then the output register. Input ready falls only while two sprites
// wait in the queue. Sprites whose index is not below SPRITE_COUNT
// are accepted and produce no entries. Scroll registers are written at any
// edge with i_cfg_we high and should be changed only while the block is idle.
module metasprite_cull_and_expand_core #(
    parameter int SCREEN_TILES_WIDE = 16,
    parameter int SCREEN_TILES_HIGH = 15,
    parameter int SPRITE_COUNT      = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [3:0] i_sprite_index,
    input  logic [7:0] i_x_tile,
    input  logic [7:0] i_x_screen,
    input  logic [3:0] i_x_fine,
    input  logic [7:0] i_y_tile,
    input  logic [7:0] i_y_screen,
    input  logic [3:0] i_y_fine,
    input  logic [7:0] i_pose_status,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [5:0] o_oam_entry,
    output logic [7:0] o_x_pos,
    output logic [7:0] o_y_pos,
    output logic       o_x_written,
    output logic [5:0] o_tile_code,
    output logic       o_flip,
    output logic       o_tile_written,
    output logic       o_last
);

    msce_pkg::t_job    job_in, job_head;
    msce_pkg::t_q_stat q_stat;
    logic              push, pop;

    msce_front #(
        .SCREEN_TILES_WIDE (SCREEN_TILES_WIDE),
        .SCREEN_TILES_HIGH (SCREEN_TILES_HIGH),
        .SPRITE_COUNT      (SPRITE_COUNT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sprite_index (i_sprite_index),
        .i_x_tile       (i_x_tile),
        .i_x_screen     (i_x_screen),
        .i_x_fine       (i_x_fine),
        .i_y_tile       (i_y_tile),
        .i_y_screen     (i_y_screen),
        .i_y_fine       (i_y_fine),
        .i_pose_status  (i_pose_status),
        .i_q_stat       (q_stat),
        .o_push         (push),
        .o_job          (job_in)
    );

    msce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_head  (job_head),
        .o_stat  (q_stat)
    );

    msce_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (job_head),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_oam_entry    (o_oam_entry),
        .o_x_pos        (o_x_pos),
        .o_y_pos        (o_y_pos),
        .o_x_written    (o_x_written),
        .o_tile_code    (o_tile_code),
        .o_flip         (o_flip),
        .o_tile_written (o_tile_written),
        .o_last         (o_last)
    );

    // last flag must track the quadrant number
    `ASSERT_IMPLIES(a_last_quadrant, i_clk, i_rst_n, o_out_valid, (o_last == (o_oam_entry[1:0] == 2'b11)), "last flag does not match quadrant")
    // an entry without x update is a hidden one
    `ASSERT_IMPLIES(a_hidden_entry, i_clk, i_rst_n, o_out_valid && !o_x_written, (o_y_pos == msce_pkg::HIDDEN_Y) && (o_x_pos == 8'd0), "hidden entry carries a position")
    // a culled sprite writes nothing but the hidden y
    `ASSERT_IMPLIES(a_culled_entry, i_clk, i_rst_n, o_out_valid && !o_tile_written, !o_x_written && (o_tile_code == 6'd0) && !o_flip, "culled entry carries data")
    // the back stage never pops an empty queue
    `ASSERT_ALWAYS(a_queue_flow, i_clk, i_rst_n, !(pop && q_stat.empty), "pop from empty queue")

endmodule

// File: test/tb_metasprite_cull_and_expand_core.sv
`timescale 1ns / 1ps

module tb_metasprite_cull_and_expand_core;

    localparam int SCREEN_TILES_WIDE = 16;
    localparam int SCREEN_TILES_HIGH = 15;
    localparam int SPRITE_COUNT      = 16;
    localparam int LIFT_LINES        = 3;
    localparam int POSE_LAST_ROW     = 6;
    localparam int ITEMS_PER_PHASE   = 60;
    localparam int SETTLE_CYCLES     = 10;
    localparam int HOLD_OFF_CYCLES   = 300;
    localparam int WATCHDOG_CYCLES   = 4000;
    localparam int PRINT_LIMIT       = 40;

    // bit 6 flip, bits 5..0 tile; 16 per pose row = 4 walk phases x 4 quadrants
    localparam logic [6:0] POSE_TABLE [112] = '{
        7'h06, 7'h07, 7'h08, 7'h09, 7'h06, 7'h07, 7'h0a, 7'h0b,
        7'h06, 7'h07, 7'h08, 7'h09, 7'h06, 7'h07, 7'h4b, 7'h4a,
        7'h00, 7'h01, 7'h02, 7'h03, 7'h00, 7'h01, 7'h04, 7'h05,
        7'h00, 7'h01, 7'h02, 7'h03, 7'h00, 7'h01, 7'h45, 7'h44,
        7'h0c, 7'h0d, 7'h0e, 7'h0f, 7'h0c, 7'h0d, 7'h10, 7'h11,
        7'h0c, 7'h0d, 7'h0e, 7'h0f, 7'h0c, 7'h0d, 7'h12, 7'h13,
        7'h4d, 7'h4c, 7'h4f, 7'h4e, 7'h4d, 7'h4c, 7'h51, 7'h50,
        7'h4d, 7'h4c, 7'h4f, 7'h4e, 7'h4d, 7'h4c, 7'h53, 7'h52,
        7'h14, 7'h15, 7'h16, 7'h17, 7'h14, 7'h15, 7'h18, 7'h19,
        7'h14, 7'h15, 7'h18, 7'h19, 7'h14, 7'h15, 7'h18, 7'h19,
        7'h55, 7'h54, 7'h57, 7'h56, 7'h55, 7'h54, 7'h59, 7'h58,
        7'h55, 7'h54, 7'h59, 7'h58, 7'h55, 7'h54, 7'h59, 7'h58,
        7'h1a, 7'h1b, 7'h1c, 7'h1d, 7'h1a, 7'h1b, 7'h1c, 7'h1d,
        7'h1a, 7'h1b, 7'h1c, 7'h1d, 7'h1a, 7'h1b, 7'h1c, 7'h1d
    };

    typedef struct packed {
        logic [3:0] sprite_index;
        logic [7:0] x_tile;
        logic [7:0] x_screen;
        logic [3:0] x_fine;
        logic [7:0] y_tile;
        logic [7:0] y_screen;
        logic [3:0] y_fine;
        logic [7:0] pose_status;
    } t_sprite;

    typedef struct packed {
        logic [5:0] oam_entry;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic       x_written;
        logic [5:0] tile_code;
        logic       flip;
        logic       tile_written;
        logic       last;
    } t_oam_attr;

    typedef struct packed {
        logic    culled;
        t_sprite spr;
    } t_directed_row;

    // culled rows carry a known all-hidden expectation, the rest go through the predictor
    localparam t_directed_row DIRECTED_ROWS [21] = '{
        '{1'b0, '{4'd0,  8'd0,   8'd0,   4'd0,  8'd0,   8'd0,   4'd0,  8'h00}},
        '{1'b0, '{4'd1,  8'd16,  8'd0,   4'd15, 8'd15,  8'd0,   4'd15, 8'h01}},
        '{1'b1, '{4'd2,  8'd17,  8'd0,   4'd0,  8'd0,   8'd0,   4'd0,  8'h10}},
        '{1'b0, '{4'd3,  8'd0,   8'd1,   4'd8,  8'd3,   8'd0,   4'd4,  8'h12}},
        '{1'b0, '{4'd4,  8'd5,   8'd0,   4'd7,  8'd4,   8'd0,   4'd9,  8'h23}},
        '{1'b1, '{4'd5,  8'd0,   8'd2,   4'd0,  8'd0,   8'd0,   4'd0,  8'h00}},
        '{1'b0, '{4'd6,  8'd14,  8'd0,   4'd15, 8'd0,   8'd1,   4'd0,  8'h33}},
        '{1'b1, '{4'd7,  8'd3,   8'd0,   4'd0,  8'd255, 8'd0,   4'd0,  8'h00}},
        '{1'b1, '{4'd8,  8'd0,   8'd0,   4'd0,  8'd16,  8'd0,   4'd0,  8'h00}},
        '{1'b1, '{4'd9,  8'd0,   8'd0,   4'd0,  8'd0,   8'd255, 4'd0,  8'h00}},
        '{1'b0, '{4'd10, 8'd2,   8'd0,   4'd3,  8'd2,   8'd0,   4'd5,  8'h40}},
        '{1'b0, '{4'd11, 8'd15,  8'd0,   4'd15, 8'd1,   8'd0,   4'd3,  8'h41}},
        '{1'b0, '{4'd12, 8'd7,   8'd0,   4'd1,  8'd8,   8'd0,   4'd2,  8'h51}},
        '{1'b0, '{4'd13, 8'd9,   8'd0,   4'd6,  8'd11,  8'd0,   4'd14, 8'h62}},
        '{1'b0, '{4'd14, 8'd1,   8'd0,   4'd9,  8'd6,   8'd0,   4'd7,  8'h6F}},
        '{1'b0, '{4'd15, 8'd4,   8'd0,   4'd2,  8'd5,   8'd0,   4'd3,  8'hF3}},
        '{1'b0, '{4'd0,  8'd8,   8'd0,   4'd0,  8'd9,   8'd0,   4'd8,  8'h7D}},
        '{1'b0, '{4'd1,  8'd12,  8'd0,   4'd11, 8'd13,  8'd0,   4'd12, 8'h0C}},
        '{1'b1, '{4'd15, 8'd255, 8'd255, 4'd15, 8'd255, 8'd255, 4'd15, 8'hFF}},
        '{1'b0, '{4'd2,  8'd10,  8'd0,   4'd4,  8'd10,  8'd0,   4'd4,  8'h20}},
        '{1'b0, '{4'd3,  8'd6,   8'd0,   4'd5,  8'd12,  8'd0,   4'd1,  8'h30}}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    msce_pkg::t_cfg_idx   i_cfg_index;
    logic [7:0]           i_cfg_wdata;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [3:0]           i_sprite_index;
    logic [7:0]           i_x_tile;
    logic [7:0]           i_x_screen;
    logic [3:0]           i_x_fine;
    logic [7:0]           i_y_tile;
    logic [7:0]           i_y_screen;
    logic [3:0]           i_y_fine;
    logic [7:0]           i_pose_status;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [5:0]           o_oam_entry;
    logic [7:0]           o_x_pos;
    logic [7:0]           o_y_pos;
    logic                 o_x_written;
    logic [5:0]           o_tile_code;
    logic                 o_flip;
    logic                 o_tile_written;
    logic                 o_last;

    logic [7:0] scroll_reg [6] = '{default: 8'd0};
    t_oam_attr  pending_entries [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;
    int quiet_cycles   = 0;
    int mismatch_count = 0;
    int sprites_sent   = 0;
    int culled_sprites = 0;
    int offscreen_quads = 0;
    int entries_checked = 0;

    metasprite_cull_and_expand_core #(
        .SCREEN_TILES_WIDE (SCREEN_TILES_WIDE),
        .SCREEN_TILES_HIGH (SCREEN_TILES_HIGH),
        .SPRITE_COUNT      (SPRITE_COUNT)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sprite_index (i_sprite_index),
        .i_x_tile       (i_x_tile),
        .i_x_screen     (i_x_screen),
        .i_x_fine       (i_x_fine),
        .i_y_tile       (i_y_tile),
        .i_y_screen     (i_y_screen),
        .i_y_fine       (i_y_fine),
        .i_pose_status  (i_pose_status),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_oam_entry    (o_oam_entry),
        .o_x_pos        (o_x_pos),
        .o_y_pos        (o_y_pos),
        .o_x_written    (o_x_written),
        .o_tile_code    (o_tile_code),
        .o_flip         (o_flip),
        .o_tile_written (o_tile_written),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // tile distance from the scroll on one axis, -1 when the sprite is culled
    function automatic int tile_distance(logic [7:0] tile, logic [7:0] screen,
                                         logic [7:0] s_tile, logic [7:0] s_screen,
                                         int span);
        int d;
        d = int'(tile) - int'(s_tile);
        if (int'(screen) == int'(s_screen) + 1)
            d += span;
        else if (screen != s_screen)
            return -1;
        if (d < 0 || d > span)
            return -1;
        return d;
    endfunction

    function automatic void predict_entries(t_sprite s);
        int        dx, dy, px, py, qx, qy, row, phase;
        bit        visible;
        logic [6:0] pose;
        t_oam_attr e;
        // sprites past the configured count give no entries
        if (int'(s.sprite_index) >= SPRITE_COUNT)
            return;
        dx = tile_distance(s.x_tile, s.x_screen, scroll_reg[msce_pkg::CFG_SCROLL_X_TILE],
                           scroll_reg[msce_pkg::CFG_SCROLL_X_SCREEN], SCREEN_TILES_WIDE);
        dy = tile_distance(s.y_tile, s.y_screen, scroll_reg[msce_pkg::CFG_SCROLL_Y_TILE],
                           scroll_reg[msce_pkg::CFG_SCROLL_Y_SCREEN], SCREEN_TILES_HIGH);
        visible = (dx >= 0) && (dy >= 0);
        px = dx * 16 + int'(s.x_fine) - int'(scroll_reg[msce_pkg::CFG_SCROLL_X_FINE]);
        py = dy * 16 + int'(s.y_fine) - int'(scroll_reg[msce_pkg::CFG_SCROLL_Y_FINE])
           - LIFT_LINES;
        row = int'(s.pose_status[7:4]);
        if (row > POSE_LAST_ROW)
            row = POSE_LAST_ROW;
        phase = int'(s.pose_status[1:0]);
        if (!visible)
            culled_sprites++;
        for (int q = 0; q < 4; q++) begin
            e = '0;
            e.oam_entry = {s.sprite_index, 2'(q)};
            e.y_pos = msce_pkg::HIDDEN_Y;
            e.last = (q == 3);
            if (visible) begin
                qx = px + (q % 2) * 8;
                qy = py + (q / 2) * 8;
                pose = POSE_TABLE[row * 16 + phase * 4 + q];
                if (qx >= 0 && qx < 256 && qy >= 0 && qy < 256) begin
                    e.x_pos = 8'(qx);
                    e.y_pos = 8'(qy);
                    e.x_written = 1'b1;
                end else begin
                    offscreen_quads++;
                end
                e.tile_code = pose[5:0];
                e.flip = pose[6];
                e.tile_written = 1'b1;
            end
            pending_entries.push_back(e);
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [5:0] entry,
                               input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("entry %0d %s got %0h want %0h",
                                      entry, name, got, want));
    endtask

    task automatic offer_sprite(input t_sprite s, input bit known_culled);
        int        gap;
        t_oam_attr e;
        i_in_valid     <= 1'b1;
        i_sprite_index <= s.sprite_index;
        i_x_tile       <= s.x_tile;
        i_x_screen     <= s.x_screen;
        i_x_fine       <= s.x_fine;
        i_y_tile       <= s.y_tile;
        i_y_screen     <= s.y_screen;
        i_y_fine       <= s.y_fine;
        i_pose_status  <= s.pose_status;
        do @(posedge i_clk); while (!o_in_ready);
        sprites_sent++;
        if (known_culled) begin
            culled_sprites++;
            for (int q = 0; q < 4; q++) begin
                e = '0;
                e.oam_entry = {s.sprite_index, 2'(q)};
                e.y_pos = 8'd254;
                e.last = (q == 3);
                pending_entries.push_back(e);
            end
        end else begin
            predict_entries(s);
        end
        gap = 0;
        while (gap < 64 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // aims one axis at the visible window, with a margin of one tile either side
    function automatic void aim_axis(input logic [7:0] s_tile, input logic [7:0] s_screen,
                                     input int span, output logic [7:0] tile,
                                     output logic [7:0] screen);
        int d, t;
        d = int'($urandom_range(span + 2)) - 1;
        if ($urandom_range(1) == 1 && s_screen != 8'd255) begin
            screen = s_screen + 8'd1;
            t = int'(s_tile) + d - span;
        end else begin
            screen = s_screen;
            t = int'(s_tile) + d;
        end
        if (t < 0 || t > 255)
            t = $urandom_range(255);
        tile = 8'(t);
    endfunction

    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (pending_entries.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_scroll(input logic [7:0] xt, input logic [7:0] xs,
                               input logic [7:0] xf, input logic [7:0] yt,
                               input logic [7:0] ys, input logic [7:0] yf);
        logic [7:0]         vals [6];
        msce_pkg::t_cfg_idx idx;
        vals = '{xt, xs, xf, yt, ys, yf};
        for (int k = 0; k < 6; k++) begin
            idx = msce_pkg::t_cfg_idx'(k);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
            if (idx == msce_pkg::CFG_SCROLL_X_FINE || idx == msce_pkg::CFG_SCROLL_Y_FINE)
                scroll_reg[idx] = vals[k] & 8'h0F;
            else
                scroll_reg[idx] = vals[k];
        end
        i_cfg_we <= 1'b0;
    endtask

    // receiver side, with an optional long hold-off counted here
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : entry_monitor
        t_oam_attr want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_entries.size() == 0) begin
                report_mismatch($sformatf("entry %0d arrived with nothing pending",
                                          o_oam_entry));
            end else begin
                want = pending_entries.pop_front();
                entries_checked++;
                check_field("oam_entry", want.oam_entry, 8'(o_oam_entry),
                            8'(want.oam_entry));
                check_field("x_pos", want.oam_entry, o_x_pos, want.x_pos);
                check_field("y_pos", want.oam_entry, o_y_pos, want.y_pos);
                check_field("x_written", want.oam_entry, 8'(o_x_written),
                            8'(want.x_written));
                check_field("tile_code", want.oam_entry, 8'(o_tile_code),
                            8'(want.tile_code));
                check_field("flip", want.oam_entry, 8'(o_flip), 8'(want.flip));
                check_field("tile_written", want.oam_entry, 8'(o_tile_written),
                            8'(want.tile_written));
                check_field("last", want.oam_entry, 8'(o_last), 8'(want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_CYCLES) begin
            $display("watchdog: no transaction for %0d cycles, %0d entries outstanding",
                     WATCHDOG_CYCLES, pending_entries.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_sprite s;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= msce_pkg::CFG_SCROLL_X_TILE;
        i_cfg_wdata    <= 8'd0;
        i_in_valid     <= 1'b0;
        i_sprite_index <= 4'd0;
        i_x_tile       <= 8'd0;
        i_x_screen     <= 8'd0;
        i_x_fine       <= 4'd0;
        i_y_tile       <= 8'd0;
        i_y_screen     <= 8'd0;
        i_y_fine       <= 4'd0;
        i_pose_status  <= 8'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed sprites against the reset scroll
        for (int r = 0; r < $size(DIRECTED_ROWS); r++)
            offer_sprite(DIRECTED_ROWS[r].spr, DIRECTED_ROWS[r].culled);

        for (int p = 0; p < 5; p++) begin
            drain_and_settle();
            case (p)
                0: load_scroll(8'd255, 8'd255, 8'd15, 8'd255, 8'd255, 8'd15);
                2: load_scroll(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                default: load_scroll(8'($urandom_range(255)), 8'($urandom_range(254)),
                                     8'($urandom_range(15)), 8'($urandom_range(255)),
                                     8'($urandom_range(254)), 8'($urandom_range(15)));
            endcase
            case (p)
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                3: begin send_idle_pct = 32; recv_stall_pct = 32; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            // sink stops dead while sprites keep coming, so the queue backs up
            if (p == 4)
                hold_cycles = HOLD_OFF_CYCLES;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                s.sprite_index = 4'($urandom_range(SPRITE_COUNT - 1));
                s.x_fine       = 4'($urandom_range(15));
                s.y_fine       = 4'($urandom_range(15));
                s.pose_status  = 8'($urandom_range(255));
                if ($urandom_range(99) < 80) begin
                    aim_axis(scroll_reg[msce_pkg::CFG_SCROLL_X_TILE],
                             scroll_reg[msce_pkg::CFG_SCROLL_X_SCREEN],
                             SCREEN_TILES_WIDE, s.x_tile, s.x_screen);
                    aim_axis(scroll_reg[msce_pkg::CFG_SCROLL_Y_TILE],
                             scroll_reg[msce_pkg::CFG_SCROLL_Y_SCREEN],
                             SCREEN_TILES_HIGH, s.y_tile, s.y_screen);
                end else begin
                    s.x_tile   = 8'($urandom_range(255));
                    s.x_screen = 8'($urandom_range(255));
                    s.y_tile   = 8'($urandom_range(255));
                    s.y_screen = 8'($urandom_range(255));
                end
                offer_sprite(s, 1'b0);
            end
        end
        drain_and_settle();

        $display("%0d sprites sent, %0d culled, %0d quadrants pushed off screen",
                 sprites_sent, culled_sprites, offscreen_quads);
        $display("%0d entries checked over reset, all-max, all-zero and random scrolls,",
                 entries_checked);
        $display("with mixed idling and one long hold-off at the output");
        if (mismatch_count == 0 && pending_entries.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d entries never arrived", mismatch_count,
                     pending_entries.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
